// ===== design/itd_pkg.sv =====
// ============================================================================
// itd_pkg
// Shared constants and types for the integer to decimal ASCII unit.
// ============================================================================
package itd_pkg;

    // Default configuration.
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS_DEF  = 10;

    // Width of one BCD digit.
    localparam int DIGIT_W = 4;

    // Character codes.
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_NINE  = 7'h39;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    // Status handed from the converter to the character emitter.
    typedef struct packed {
        logic valid;   // BCD digits are complete and waiting
        logic neg;     // the number was negative
    } t_bcd_status;

endpackage

// ===== design/itd_bcd.sv =====
// ============================================================================
// itd_bcd
// Bit-serial binary to BCD converter (shift and add-three), one bit per cycle.
// ============================================================================
module itd_bcd
    import itd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [VALUE_WIDTH-1:0]        i_value,
    input  logic                          i_taken,
    output logic                          o_busy,
    output t_bcd_status                   o_status,
    output logic [MAX_DIGITS*DIGIT_W-1:0] o_digits
);

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic                   r_neg, n_neg;
    logic [BCD_W-1:0]       w_adj;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                w_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                w_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Sequencer: load the magnitude, shift it in MSB first, then hold.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_neg   = i_value[VALUE_WIDTH-1];
                    n_bin   = i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
                    n_bcd   = '0;
                    n_cnt   = CNT_W'(VALUE_WIDTH);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                // The top digit's carry falls off, keeping the low digits only.
                n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_taken) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_status.valid = (r_state == ST_HOLD);
    assign o_status.neg   = r_neg;
    assign o_digits       = r_bcd;

endmodule

// ===== design/itd_emit.sv =====
// ============================================================================
// itd_emit
// Character emitter: drops leading zeros and sends one ASCII character a word.
// ============================================================================
module itd_emit
    import itd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_bcd_status                   i_status,
    input  logic [MAX_DIGITS*DIGIT_W-1:0] i_digits,
    output logic                          o_taken,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [6:0]                    o_char_code,
    output logic                          o_last
);

    localparam int BCD_W  = MAX_DIGITS * DIGIT_W;
    localparam int LEFT_W = $clog2(MAX_DIGITS + 1);

    logic              r_active;
    logic              r_minus;
    logic              r_lead;
    logic [LEFT_W-1:0] r_left;
    logic [BCD_W-1:0]  r_digits;
    logic              r_valid;
    logic [6:0]        r_char;
    logic              r_last;

    logic               w_free;
    logic [DIGIT_W-1:0] w_top;
    logic               w_skip;
    logic               w_emit_minus;
    logic               w_emit_digit;

    assign o_taken      = !r_active && i_status.valid;
    assign w_free       = !r_valid || !i_stall;
    assign w_top        = r_digits[BCD_W-1 -: DIGIT_W];
    // A leading zero is dropped unless it is the only digit left.
    assign w_skip       = r_active && r_lead && (w_top == '0) && (r_left > LEFT_W'(1));
    assign w_emit_minus = r_active && r_minus && w_free;
    assign w_emit_digit = r_active && !w_skip && !r_minus && w_free;

    // Digit shift register and sequencing flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_taken) begin
            r_active <= 1'b1;
        end else if (w_emit_digit && (r_left == LEFT_W'(1))) begin
            r_active <= 1'b0;
        end

        if (o_taken) begin
            r_digits <= i_digits;
            r_left   <= LEFT_W'(MAX_DIGITS);
            r_minus  <= i_status.neg;
            r_lead   <= 1'b1;
        end else begin
            if (w_skip || w_emit_digit) begin
                r_digits <= {r_digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                r_left   <= r_left - 1'b1;
            end
            if (w_emit_digit) begin
                r_lead <= 1'b0;
            end
            if (w_emit_minus) begin
                r_minus <= 1'b0;
            end
        end
    end

    // Output register: reloads whenever the current word is taken or empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= w_emit_minus || w_emit_digit;
        end
        if (w_free) begin
            if (w_emit_minus) begin
                r_char <= CHAR_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= CHAR_ZERO + {3'b000, w_top};
                r_last <= (r_left == LEFT_W'(1));
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

// ===== design/integer_to_decimal_ascii_unit.sv =====
// ============================================================================
// integer_to_decimal_ascii_unit
// Prints a signed integer as decimal ASCII text, one character per word.
// ============================================================================
// Each input word is a two's complement integer; the output is its decimal
// text, a minus sign first for negative values, then the digits most
// significant first, with last set on the final character. The magnitude is
// converted to BCD one bit per cycle, and the converter stays busy, stalling
// the input, until the emitter has taken its digits. Characters then leave
// one per cycle, unless the output stalls, from a separate emitter, which
// drops leading zeros at one digit a cycle and overlaps with the conversion
// of the next number.
module integer_to_decimal_ascii_unit
    import itd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [6:0]             o_char_code,
    output logic                   o_last
);

    t_bcd_status                   w_status;
    logic [MAX_DIGITS*DIGIT_W-1:0] w_digits;
    logic                          w_taken;
    logic                          w_busy;

    assign o_stall = w_busy;

    // Binary to BCD conversion.
    itd_bcd #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_valid && !w_busy),
        .i_value  (i_value),
        .i_taken  (w_taken),
        .o_busy   (w_busy),
        .o_status (w_status),
        .o_digits (w_digits)
    );

    // Character output.
    itd_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (w_status),
        .i_digits    (w_digits),
        .o_taken     (w_taken),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    // Finished digits stay offered until the emitter takes them.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.valid && !w_taken |=> w_status.valid)
        else $error("converted digits dropped before hand-off");

    // An accepted number blocks the input on the following cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted while conversion starts");

    // Only a minus sign or a decimal digit is ever sent.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CHAR_MINUS) ||
                    ((o_char_code >= CHAR_ZERO) && (o_char_code <= CHAR_NINE)))
        else $error("illegal character code");

    // A minus sign never ends a number.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_char_code == CHAR_MINUS) |-> !o_last)
        else $error("minus sign flagged as last character");
`endif

endmodule

// ===== tb/itd_text_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// itd_text_checker
// Watches both channels of the integer to decimal ASCII unit and checks text.
// ============================================================================
// Every accepted input word is turned into the characters of its decimal
// text. The optional minus sign comes first, then the digits with the most
// significant first. These characters are queued in order. Every accepted
// output word is compared with the oldest queued character, on both the
// code and the last flag. Mismatches and output words with nothing queued
// are counted as failures. The count and the number of characters still
// due are handed to the testbench top.
module itd_text_checker
    import itd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [VALUE_WIDTH-1:0] i_in_value,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [6:0]             i_out_char,
    input  logic                   i_out_last,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_words_seen,
    output int                     o_chars_seen
);

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_text_char;

    // Characters still owed by the unit, oldest first.
    t_text_char due_chars[$];

    // Appends the decimal text of one value to the queue of due characters.
    function automatic void queue_decimal_text(input logic [VALUE_WIDTH-1:0] value);
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
        logic [DIGIT_W-1:0]     digits [MAX_DIGITS];
        int                     nd;
        int                     i;
        t_text_char             ch;
        neg = value[VALUE_WIDTH-1];
        // The magnitude is taken as unsigned, so the most negative value fits.
        mag = neg ? (~value + 1'b1) : value;
        nd  = 0;
        while (mag != 0 && nd < MAX_DIGITS) begin
            digits[nd] = DIGIT_W'(mag % 10);
            mag        = mag / 10;
            nd++;
        end
        if (neg) begin
            ch.code = CHAR_MINUS;
            ch.last = 1'b0;
            due_chars.push_back(ch);
        end
        if (nd == 0) begin
            ch.code = CHAR_ZERO;
            ch.last = 1'b1;
            due_chars.push_back(ch);
        end else begin
            for (i = nd - 1; i >= 0; i--) begin
                ch.code = CHAR_ZERO + 7'(digits[i]);
                ch.last = (i == 0);
                due_chars.push_back(ch);
            end
        end
    endfunction

    // Counters clear during reset; both channels are sampled at each rising
    // edge after it.
    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            due_chars.delete();
            o_fail_count = 0;
            o_words_seen = 0;
            o_chars_seen = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                queue_decimal_text(i_in_value);
                o_words_seen++;
            end
            if (i_out_valid && !i_out_stall) begin
                o_chars_seen++;
                if (due_chars.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected output word: code %h last %b",
                                 $time, i_out_char, i_out_last);
                    o_fail_count++;
                end else begin
                    want = due_chars.pop_front();
                    if (want.code !== i_out_char || want.last !== i_out_last) begin
                        if (o_fail_count < 10)
                            $display("%0t: char mismatch: expected code %h last %b, got %h %b",
                                     $time, want.code, want.last, i_out_char, i_out_last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = due_chars.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Testbench top for the integer to decimal ASCII unit.
// ============================================================================
// Sends a directed set of values first: zero, single digits, the powers of
// ten, both ends of the 32-bit range and their neighbors. Random values then
// cover every digit count with either sign, along with full-range words.
// The sender works in bursts with random gaps. The receiver stalls at random
// rates and once holds off for a long stretch, so that the unit backs up.
// A checker beside the unit predicts and compares every character.
module tb
    import itd_pkg::*;
();

    localparam int RANDOM_WORDS = 380;
    localparam int HOLD_START   = 3000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 60;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [VALUE_WIDTH_DEF-1:0] i_value;
    logic                       o_valid;
    logic                       i_stall;
    logic [6:0]                 o_char_code;
    logic                       o_last;

    int fail_count;
    int pending;
    int words_seen;
    int chars_seen;

    integer_to_decimal_ascii_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    itd_text_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_value   (i_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_char   (o_char_code),
        .i_out_last   (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_words_seen (words_seen),
        .o_chars_seen (chars_seen)
    );

    // Clock with a 10 ns period.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety limit on the whole run.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Offers one word and holds it until the unit takes it.
    task automatic send_word(input logic [VALUE_WIDTH_DEF-1:0] value);
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drops valid for a number of cycles between bursts.
    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Receiver: random stall rate, redrawn from four settings during the run, with one long
    // hold-off while the sender keeps offering words.
    initial begin
        int cycle;
        int stall_pct;
        cycle     = 0;
        stall_pct = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (cycle == HOLD_START) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                cycle += HOLD_CYCLES;
            end
            if (cycle % 50 == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [VALUE_WIDTH_DEF-1:0] directed_words [$];
        logic [VALUE_WIDTH_DEF-1:0] mag;
        logic [VALUE_WIDTH_DEF-1:0] value;
        int unsigned                lo;
        int unsigned                hi;
        int                         nd;
        int                         burst;
        int                         sent;
        int                         k;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed values: zero, digit boundaries and both range ends.
        directed_words = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10,
                           -32'sd10, 32'sd99, 32'sd100, 32'sd12345, -32'sd67890,
                           32'sd999999999, 32'sd1000000000, -32'sd1000000000,
                           32'sd1234567890, -32'sd987654321, 32'h7FFF_FFFF,
                           32'h7FFF_FFFE, 32'h8000_0000, 32'h8000_0001,
                           32'hAAAA_AAAA, 32'h5555_5555};
        foreach (directed_words[i]) begin
            send_word(directed_words[i]);
            idle_gap($urandom_range(0, 3));
        end

        // Random values in bursts of random length.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 10);
            for (k = 0; k < burst; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: value = $urandom();
                    3, 4, 5, 6, 7: begin
                        // A magnitude with a chosen number of digits.
                        nd = $urandom_range(1, 10);
                        lo = 1;
                        repeat (nd - 1) lo = lo * 10;
                        hi    = (nd == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
                        mag   = $urandom_range(hi, lo);
                        value = $urandom_range(0, 1) ? -mag : mag;
                    end
                    8:       value = $urandom_range(0, 40) - 20;
                    default: value = $urandom_range(0, 1) ?
                                     32'h7FFF_FFFF - $urandom_range(0, 15) :
                                     32'h8000_0000 + $urandom_range(0, 15);
                endcase
                send_word(value);
                sent++;
            end
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end
        i_valid <= 1'b0;

        // Drain every due character, then allow for the unit's latency.
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d words and %0d characters: zero, range ends, every digit count,",
                 words_seen, chars_seen);
        $display("both signs, bursty input, random output stalls and one long output hold.");
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
